// ===== sv/dtlv_pkg.sv =====
// ----------------------------------------------------------------------------
// dtlv_pkg
// Types and constants shared by the DER TLV header parser and its channels.
// ----------------------------------------------------------------------------
package dtlv_pkg;

  localparam int unsigned MAX_LENGTH_OCTETS = 4;
  localparam int unsigned MAX_TAG_GROUPS    = 5;
  localparam logic [4:0]  TAG_LONG_FORM     = 5'h1F;

  typedef enum logic [2:0] {
    PH_IDENT     = 3'd0,
    PH_TAG       = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_VAL = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] tag_acc;
    logic [2:0]  tag_grp;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [3:0]  hdr_cnt;
    logic [31:0] val_left;
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tag_number;
    logic [31:0] value_length;
    logic [3:0]  header_bytes;
    logic [7:0]  value_byte;
    logic        last_of_object;
  } result_t;

endpackage

// ===== sv/dtlv_intf.sv =====
// ----------------------------------------------------------------------------
// dtlv channel interfaces
// Byte input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_message;

  modport source (output valid, output data_byte, output start_of_message, input ready);
  modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface dtlv_out_if
  import dtlv_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [31:0] tag_number;
  logic [31:0] value_length;
  logic [3:0]  header_bytes;
  logic [7:0]  value_byte;
  logic        last_of_object;

  modport source (output valid, output kind, output tag_number, output value_length,
                  output header_bytes, output value_byte, output last_of_object,
                  input ready);
  modport sink   (input valid, input kind, input tag_number, input value_length,
                  input header_bytes, input value_byte, input last_of_object,
                  output ready);
endinterface

// ===== sv/der_tlv_header_parser.sv =====
// Result path: a result is registered into the output register, or into the
// skid entry while the output register still holds an earlier result.
// Throughput: one byte per cycle; a two-entry output buffer (register plus
// skid) lets input continue while a result waits, ready drops only when both
// entries are full.
// Reset: synchronous, active low; parser returns to expecting an identifier.
// ----------------------------------------------------------------------------
// der_tlv_header_parser
// ASN.1 DER TLV parser: header or error results for identifier/length
// octets, then pass-through of content bytes.
// ----------------------------------------------------------------------------
module der_tlv_header_parser
  import dtlv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dtlv_in_if.sink           in_chan,
  dtlv_out_if.source        out_chan
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         has_res;
  result_t      res;

  result_t      o_r;
  result_t      s_r;
  logic         ov_r;
  logic         sv_r;

  logic         in_fire;
  logic         push;
  logic         pop;

  dtlv_parse u_parse (
    .st               (st_r),
    .data_byte        (in_chan.data_byte),
    .start_of_message (in_chan.start_of_message),
    .st_nxt           (st_nxt),
    .has_res          (has_res),
    .res              (res)
  );

  assign in_chan.ready = !sv_r;
  assign in_fire       = in_chan.valid && !sv_r;
  assign push          = in_fire && has_res;
  assign pop           = ov_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDENT, default: '0};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (pop) begin
      if (sv_r) begin
        sv_r <= push;
      end else begin
        ov_r <= push;
      end
    end else if (!ov_r) begin
      ov_r <= push;
    end else if (push) begin
      sv_r <= 1'b1;
    end
  end

  // payload moves: skid drains into the output register on a transfer out
  always_ff @(posedge clk) begin
    if (pop) begin
      if (sv_r) begin
        o_r <= s_r;
        if (push) begin
          s_r <= res;
        end
      end else if (push) begin
        o_r <= res;
      end
    end else if (!ov_r) begin
      if (push) begin
        o_r <= res;
      end
    end else if (push) begin
      s_r <= res;
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.kind           = o_r.kind;
  assign out_chan.tag_number     = o_r.tag_number;
  assign out_chan.value_length   = o_r.value_length;
  assign out_chan.header_bytes   = o_r.header_bytes;
  assign out_chan.value_byte     = o_r.value_byte;
  assign out_chan.last_of_object = o_r.last_of_object;

`ifndef ASSERT_OFF
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held while output register empty");

  a_value_left : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_VALUE) |-> (st_r.val_left != '0))
    else $error("value phase with no bytes left");

  a_hdr_last : assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_r.kind == KIND_HDR) |->
      (o_r.last_of_object == (o_r.value_length == '0)))
    else $error("header last flag disagrees with length");

  a_err_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_r.kind == KIND_ERR) |->
      (o_r.header_bytes >= 4'd2 && o_r.header_bytes <= 4'd7 && o_r.last_of_object))
    else $error("error result with bad header byte count");

  a_hdr_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hdr_cnt <= 4'd10)
    else $error("header byte count out of range");
`endif

endmodule

// ===== sv/dtlv_parse.sv =====
// ----------------------------------------------------------------------------
// dtlv_parse
// Per-byte next-state and result logic of the TLV parser (combinational).
// ----------------------------------------------------------------------------
module dtlv_parse
  import dtlv_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         start_of_message,
  output parse_state_t st_nxt,
  output logic         has_res,
  output result_t      res
);

  phase_t      ph;
  logic [3:0]  hc_inc;
  logic        do_hdr;
  logic        do_err;
  logic [31:0] hdr_len;
  logic [31:0] len_shift;
  logic [2:0]  left_dec;
  logic [31:0] val_dec;

  always_comb begin
    st_nxt    = st;
    has_res   = 1'b0;
    res       = '0;
    do_hdr    = 1'b0;
    do_err    = 1'b0;
    hdr_len   = '0;
    ph        = start_of_message ? PH_IDENT : st.phase;
    hc_inc    = st.hdr_cnt + 4'd1;
    len_shift = {st.len_acc[23:0], data_byte};
    left_dec  = st.len_left - 3'd1;
    val_dec   = st.val_left - 32'd1;

    unique case (ph)
      PH_IDENT: begin
        st_nxt.hdr_cnt  = 4'd1;
        st_nxt.tag_grp  = '0;
        st_nxt.len_acc  = '0;
        st_nxt.len_left = '0;
        if (data_byte[4:0] != TAG_LONG_FORM) begin
          st_nxt.tag_acc = {27'd0, data_byte[4:0]};
          st_nxt.phase   = PH_LEN_FIRST;
        end else begin
          st_nxt.tag_acc = '0;
          st_nxt.phase   = PH_TAG;
        end
      end
      PH_TAG: begin
        st_nxt.hdr_cnt = hc_inc;
        // reject a sixth group or one that would overflow 32 bits
        if (st.tag_grp >= 3'(MAX_TAG_GROUPS) || st.tag_acc[31:25] != '0) begin
          do_err = 1'b1;
        end else begin
          st_nxt.tag_acc = {st.tag_acc[24:0], data_byte[6:0]};
          st_nxt.tag_grp = st.tag_grp + 3'd1;
          if (!data_byte[7]) begin
            st_nxt.phase = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        st_nxt.hdr_cnt = hc_inc;
        if (!data_byte[7]) begin
          do_hdr  = 1'b1;
          hdr_len = {25'd0, data_byte[6:0]};
        end else if (data_byte[6:0] == '0) begin
          do_hdr  = 1'b1;
        end else if (data_byte[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
          do_err = 1'b1;
        end else begin
          st_nxt.len_left = data_byte[2:0];
          st_nxt.len_acc  = '0;
          st_nxt.phase    = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        st_nxt.hdr_cnt  = hc_inc;
        st_nxt.len_acc  = len_shift;
        st_nxt.len_left = left_dec;
        if (left_dec == '0) begin
          do_hdr  = 1'b1;
          hdr_len = len_shift;
        end
      end
      PH_VALUE: begin
        st_nxt.val_left    = val_dec;
        has_res            = 1'b1;
        res.kind           = KIND_VAL;
        res.value_byte     = data_byte;
        res.last_of_object = (val_dec == '0);
        if (val_dec == '0) begin
          st_nxt.phase = PH_IDENT;
        end
      end
      default: begin
        st_nxt.phase = PH_IDENT;
      end
    endcase

    if (do_err) begin
      has_res            = 1'b1;
      res.kind           = KIND_ERR;
      res.header_bytes   = hc_inc;
      res.last_of_object = 1'b1;
      st_nxt.phase       = PH_IDENT;
      st_nxt.hdr_cnt     = '0;
    end

    if (do_hdr) begin
      has_res            = 1'b1;
      res.kind           = KIND_HDR;
      res.tag_number     = st.tag_acc;
      res.value_length   = hdr_len;
      res.header_bytes   = hc_inc;
      res.last_of_object = (hdr_len == '0);
      st_nxt.len_acc     = hdr_len;
      st_nxt.val_left    = hdr_len;
      st_nxt.phase       = (hdr_len == '0) ? PH_IDENT : PH_VALUE;
      st_nxt.hdr_cnt     = '0;
    end
  end

endmodule

// ===== tb/tlv_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlv_result_checker
// Watches the byte and result channels of the DER TLV parser. Every accepted
// byte runs through a local parser model; the results it produces are queued
// and compared field by field, in order, with each result transfer.
// ----------------------------------------------------------------------------
module tlv_result_checker
  import dtlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dtlv_in_if          byte_tap,
  dtlv_out_if         result_tap,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned bytes_in,
  output int unsigned headers_seen,
  output int unsigned values_seen,
  output int unsigned errors_seen
);

  parse_state_t ps;
  result_t      pending_results[$];

  // bad header: report the bytes consumed so far and hunt for an identifier
  function automatic result_t header_error();
    result_t r;
    r = '{kind: KIND_ERR, tag_number: '0, value_length: '0,
          header_bytes: ps.hdr_cnt, value_byte: '0, last_of_object: 1'b1};
    ps.phase   = PH_IDENT;
    ps.hdr_cnt = '0;
    return r;
  endfunction

  function automatic result_t header_done();
    result_t r;
    logic    empty;
    empty = (ps.len_acc == '0);
    r = '{kind: KIND_HDR, tag_number: ps.tag_acc, value_length: ps.len_acc,
          header_bytes: ps.hdr_cnt, value_byte: '0, last_of_object: empty};
    ps.val_left = ps.len_acc;
    ps.phase    = empty ? PH_IDENT : PH_VALUE;
    ps.hdr_cnt  = '0;
    return r;
  endfunction

  // advances the parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic som,
                                    output result_t r);
    r = '0;
    if (som) ps.phase = PH_IDENT;
    case (ps.phase)
      PH_IDENT: begin
        ps.hdr_cnt  = 4'd1;
        ps.tag_grp  = '0;
        ps.len_acc  = '0;
        ps.len_left = '0;
        if (b[4:0] != TAG_LONG_FORM) begin
          ps.tag_acc = {27'd0, b[4:0]};
          ps.phase   = PH_LEN_FIRST;
        end else begin
          ps.tag_acc = '0;
          ps.phase   = PH_TAG;
        end
        return 1'b0;
      end
      PH_TAG: begin
        ps.hdr_cnt = ps.hdr_cnt + 4'd1;
        // sixth group, or a group that would push set bits past bit 31
        if (ps.tag_grp >= MAX_TAG_GROUPS || ps.tag_acc[31:25] != '0) begin
          r = header_error();
          return 1'b1;
        end
        ps.tag_acc = {ps.tag_acc[24:0], b[6:0]};
        ps.tag_grp = ps.tag_grp + 3'd1;
        if (!b[7]) ps.phase = PH_LEN_FIRST;
        return 1'b0;
      end
      PH_LEN_FIRST: begin
        ps.hdr_cnt = ps.hdr_cnt + 4'd1;
        // short form, and 0x80 which counts as length zero
        if (!b[7] || b[6:0] == '0) begin
          ps.len_acc = {25'd0, b[6:0]};
          r = header_done();
          return 1'b1;
        end
        if (b[6:0] > MAX_LENGTH_OCTETS) begin
          r = header_error();
          return 1'b1;
        end
        ps.len_left = b[2:0];
        ps.len_acc  = '0;
        ps.phase    = PH_LEN_MORE;
        return 1'b0;
      end
      PH_LEN_MORE: begin
        ps.hdr_cnt  = ps.hdr_cnt + 4'd1;
        ps.len_acc  = {ps.len_acc[23:0], b};
        ps.len_left = ps.len_left - 3'd1;
        if (ps.len_left == '0) begin
          r = header_done();
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        ps.val_left = ps.val_left - 32'd1;
        r = '{kind: KIND_VAL, tag_number: '0, value_length: '0, header_bytes: '0,
              value_byte: b, last_of_object: (ps.val_left == '0)};
        if (ps.val_left == '0) ps.phase = PH_IDENT;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t next_r;
    if (!rst_n) begin
      ps       = '0;
      ps.phase = PH_IDENT;
      pending_results.delete();
      fail_count   = 0;
      bytes_in     = 0;
      headers_seen = 0;
      values_seen  = 0;
      errors_seen  = 0;
    end else begin
      if (byte_tap.valid && byte_tap.ready) begin
        bytes_in++;
        if (parse_byte(byte_tap.data_byte, byte_tap.start_of_message, next_r))
          pending_results.push_back(next_r);
      end
      if (result_tap.valid && result_tap.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected, kind %0d", result_tap.kind);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(result_tap.kind));
          check_field("tag_number", want.tag_number, result_tap.tag_number);
          check_field("value_length", want.value_length, result_tap.value_length);
          check_field("header_bytes", 32'(want.header_bytes),
                      32'(result_tap.header_bytes));
          check_field("value_byte", 32'(want.value_byte), 32'(result_tap.value_byte));
          check_field("last_of_object", 32'(want.last_of_object),
                      32'(result_tap.last_of_object));
          case (want.kind)
            KIND_HDR: headers_seen++;
            KIND_VAL: values_seen++;
            default:  errors_seen++;
          endcase
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== tb/tb_der_tlv_header_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_der_tlv_header_parser
// Feeds the DER TLV parser a short directed byte stream and then random
// objects, mostly well formed, with noise, broken headers and cut-off values
// mixed in. Both channels idle at random; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_der_tlv_header_parser;
  import dtlv_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1050;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam logic [8:0]  SOM          = 9'h100;

  logic clk = 1'b0;
  logic rst_n;

  dtlv_in_if  byte_chan ();
  dtlv_out_if result_chan ();

  int unsigned fail_count, pending, bytes_in;
  int unsigned headers_seen, values_seen, errors_seen;
  int unsigned cycle_count;
  int unsigned sent_bytes;
  int unsigned burst_left;
  bit          gaps_on;
  bit          at_boundary;
  bit          drained;
  int unsigned hold_asks;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned stall_pct;
  int unsigned rx_ticks;
  logic [8:0]  opening [29];

  der_tlv_header_parser DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (byte_chan),
    .out_chan(result_chan)
  );

  tlv_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_tap    (byte_chan),
    .result_tap  (result_chan),
    .fail_count  (fail_count),
    .pending     (pending),
    .bytes_in    (bytes_in),
    .headers_seen(headers_seen),
    .values_seen (values_seen),
    .errors_seen (errors_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall rate, redrawn periodically, plus requested long holds
  always @(posedge clk) begin
    rx_ticks++;
    if (rx_ticks % 64 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_chan.ready <= 1'b0;
    end else begin
      result_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic som);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        byte_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_chan.valid            <= 1'b1;
    byte_chan.data_byte        <= b;
    byte_chan.start_of_message <= som;
    @(posedge clk);
    while (byte_chan.ready !== 1'b1) @(posedge clk);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic drain_results();
    byte_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one object; a forced start is used whenever the parser may be mid-object
  task automatic send_object();
    logic        som;
    int unsigned pick, groups, lead, val_count;
    logic [6:0]  content;
    logic [31:0] len;
    som = at_boundary ? ($urandom_range(0, 1) == 1) : 1'b1;
    at_boundary = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      return;
    end

    if ($urandom_range(0, 2) != 0) begin
      send_byte({3'($urandom), 5'($urandom_range(0, 30))}, som);
    end else begin
      send_byte({3'($urandom), TAG_LONG_FORM}, som);
      // below 6: too many groups; 6..11: five groups overflowing 32 bits
      pick = $urandom_range(0, 99);
      groups = (pick < 6) ? 6 : (pick < 12) ? 5 : $urandom_range(1, 5);
      for (int g = 0; g < groups; g++) begin
        content = 7'($urandom);
        if (g == 0 && groups == 5)
          content = (pick < 12) ? 7'($urandom_range(16, 127)) : (content & 7'h0F);
        if (groups == 6 && g < 2)
          content = (g == 0) ? 7'd0 : (content & 7'h0F);
        send_byte({(g != groups - 1), content}, 1'b0);
      end
      if (pick < 12) return;
    end

    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte({1'b1, 7'($urandom_range(MAX_LENGTH_OCTETS + 1, 127))}, 1'b0);
      return;
    end
    // huge lengths are abandoned after a few content bytes
    if (pick < 10) len = $urandom;
    else if (pick < 20) len = $urandom_range(9, 40);
    else len = $urandom_range(0, 8);
    if (pick >= 10 && len < 128 && $urandom_range(0, 1) == 1) begin
      send_byte((len == 0 && $urandom_range(0, 1) == 1) ? 8'h80 : 8'(len), 1'b0);
    end else begin
      lead = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
      lead = $urandom_range(lead, MAX_LENGTH_OCTETS);
      send_byte(8'h80 | 8'(lead), 1'b0);
      for (int k = lead - 1; k >= 0; k--) send_byte(8'(len >> (8 * k)), 1'b0);
    end
    val_count = (pick < 10) ? $urandom_range(0, 6) : len;
    repeat (val_count) send_byte(8'($urandom), 1'b0);
    at_boundary = (pick >= 10);
  endtask

  initial begin
    byte_chan.valid            = 1'b0;
    byte_chan.data_byte        = '0;
    byte_chan.start_of_message = 1'b0;
    rst_n       = 1'b0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    at_boundary = 1'b0;
    drained     = 1'b0;
    opening = '{
      SOM | 9'h000, 9'h000,                                // tag 0, empty
      9'h0FE, 9'h001, 9'h000,                              // tag 30, class bits set
      9'h01F, 9'h09F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,      // tag overflows 32 bits
      9'h03F, 9'h08F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,      // tag all ones
      9'h080,                                              // 0x80 gives length 0
      9'h001, 9'h0FF,                                      // too many length bytes
      9'h002, 9'h084, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,      // max length
      9'h0FF,
      SOM | 9'h01F, 9'h081                                 // forced start mid-object
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

    while (sent_bytes < $size(opening) + RANDOM_BYTES) begin
      if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
      if (sent_bytes >= 300 && hold_asks == 0) begin
        hold_asks <= 1;
        gaps_on = 1'b0;
      end
      if (sent_bytes >= 800 && hold_asks == 1) begin
        hold_asks <= 2;
        gaps_on = 1'b0;
      end
      if (sent_bytes >= 600 && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      send_object();
    end

    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    $display("covered %0d bytes: %0d headers, %0d value bytes, %0d format errors",
             bytes_in, headers_seen, values_seen, errors_seen);
    $display("with two long result holds, one full drain and random gaps on both sides");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
